/* hw/rtl/sarena_pkg.sv */
// ---------------------------------------------------------------------------
// Stack arena allocator package
// Shared widths, command and status codes, word types and helper functions.
// ---------------------------------------------------------------------------
package sarena_pkg;

  localparam int unsigned ARENA_BYTES    = 4096;
  localparam int unsigned RECORD_BYTES   = 4;
  localparam int unsigned REC_DEPTH      = ARENA_BYTES / RECORD_BYTES;
  localparam int unsigned REC_AW         = $clog2(REC_DEPTH);
  localparam int unsigned REC_W          = 16;
  localparam int unsigned MIN_ALIGN_LOG2 = 2;
  localparam int unsigned MAX_ALIGN_LOG2 = 9;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_EXPAND = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NOTGROWN = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [12:0] req_bytes;
    logic [3:0]  align_log2;
    logic [11:0] chunk_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] result_offset;
    logic [12:0] granted_bytes;
  } out_item_t;

  // Alignment mask for a log2 alignment of at most nine.
  function automatic logic [8:0] align_mask(logic [3:0] alog);
    logic [9:0] one_hot;
    one_hot = 10'd1 << alog;
    return 9'(one_hot - 10'd1);
  endfunction

  // Free bytes left between the data end and the lowest chunk record.
  function automatic logic [12:0] free_bytes(logic [12:0] used, logic [10:0] count);
    logic [13:0] taken;
    taken = {1'b0, used} + {1'b0, count, 2'b00};
    if (taken >= 14'(ARENA_BYTES)) begin
      return 13'd0;
    end
    return 13'(14'(ARENA_BYTES) - taken);
  endfunction

endpackage

/* hw/rtl/sarena_ram.sv */
// ---------------------------------------------------------------------------
// Stack arena record RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module sarena_ram #(
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/stack_arena_allocator.sv */
// ---------------------------------------------------------------------------
// Stack arena allocator
// Allocates, frees and grows chunks of a 4096-byte arena managed as a stack.
// ---------------------------------------------------------------------------
// Usage:
// Commands enter on the in channel (valid/ready); each command word yields
// exactly one result word on the out channel (valid/ready). The cfg channel
// writes max_alloc_bytes and is always ready; write it only while idle.
// One command is worked on at a time; the next is taken as soon as the
// previous one has placed its result in the output register, even if the
// receiver has not yet taken that result.
// Steps from acceptance to the result register:
//   alloc: size and padding, fit check and record push, handoff.
//   free: records are scanned from the newest down to the match (one
//   record RAM read per cycle), then each free record on top is popped
//   (read then check) until a used record or an empty stack, then handoff.
//   expand: top record read, limit, grant, handoff.
//   Bad commands and empty-stack cases go straight to the handoff.
// The record RAM port (one read per cycle) sets the pace of free.
// Reset clears bytes used and the record count and sets max_alloc_bytes to
// 4096; the record RAM is not cleared since only written entries are read.
// A stalled receiver holds the result register; a finished command then
// waits in its handoff step and no new command is taken until it drains.
// ---------------------------------------------------------------------------
module stack_arena_allocator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [12:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sarena_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sarena_pkg::out_item_t out_data_o
);

  localparam int unsigned AW = sarena_pkg::REC_AW;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ALC     = 4'd1;
  localparam logic [3:0] S_ALC_FIT = 4'd2;
  localparam logic [3:0] S_SRCH    = 4'd3;
  localparam logic [3:0] S_POP_RD  = 4'd4;
  localparam logic [3:0] S_POP_CHK = 4'd5;
  localparam logic [3:0] S_EXP     = 4'd6;
  localparam logic [3:0] S_EXP_FIN = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [12:0] used_q, used_d;
  logic [10:0] count_q, count_d;
  logic [12:0] max_q;
  logic        out_valid_q, out_valid_d;

  // Per-command working registers.
  logic [12:0] req_q, req_d;
  logic [3:0]  alog_q, alog_d;
  logic [11:0] off_q, off_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [13:0] size_q, size_d;
  logic [8:0]  pad_q, pad_d;
  logic [12:0] room_q, room_d;
  logic [12:0] cur_q, cur_d;
  logic [12:0] limit_q, limit_d;
  sarena_pkg::out_item_t pend_q, pend_d;
  sarena_pkg::out_item_t out_q, out_d;

  // Record RAM port signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_wdata;
  logic [15:0]       ram_rdata;

  // Datapath helpers.
  logic [8:0]  alc_mask;
  logic [13:0] alc_size;
  logic [12:0] alc_avail;
  logic [14:0] fit_need;
  logic [12:0] fit_off;
  logic [11:0] top_off;
  logic [8:0]  top_mask;
  logic [12:0] top_cur;
  logic [12:0] top_limit;
  logic [12:0] exp_want;
  logic [12:0] exp_new;
  logic [AW-1:0] top_addr;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign top_addr = AW'(count_q - 11'd1);

  // Alloc sizing: round the size up and pad the data end to the alignment.
  assign alc_mask  = sarena_pkg::align_mask(alog_q);
  assign alc_size  = ({1'b0, req_q} + {5'd0, alc_mask}) & ~{5'd0, alc_mask};
  assign alc_avail = sarena_pkg::free_bytes(used_q, count_q);

  // Alloc fit: chunk plus padding against the room left after one more record.
  assign fit_need = {1'b0, size_q} + {6'd0, pad_q};
  assign fit_off  = used_q + {4'd0, pad_q};

  // Expand: the top record's chunk may grow up to the aligned free space.
  assign top_off   = ram_rdata[15:4];
  assign top_mask  = sarena_pkg::align_mask(4'(ram_rdata[3:1]) + 4'(sarena_pkg::MIN_ALIGN_LOG2));
  assign top_cur   = used_q - {1'b0, top_off};
  assign top_limit = (alc_avail + top_cur) & ~{4'd0, top_mask};
  assign exp_want  = (req_q > cur_q) ? req_q : cur_q;
  assign exp_new   = (exp_want < limit_q) ? exp_want : limit_q;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    alog_d      = alog_q;
    off_d       = off_q;
    addr_d      = addr_q;
    size_d      = size_q;
    pad_d       = pad_q;
    room_d      = room_q;
    cur_d       = cur_q;
    limit_d     = limit_q;
    pend_d      = pend_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = top_addr;
    ram_wdata   = ram_rdata;
    ram_raddr   = top_addr;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_data_i.req_bytes;
          off_d  = in_data_i.chunk_offset;
          addr_d = top_addr;
          pend_d = '{status: sarena_pkg::ST_OK, result_offset: '0, granted_bytes: '0};
          case (in_data_i.cmd)
            sarena_pkg::CMD_ALLOC: begin
              if ((in_data_i.align_log2 > 4'(sarena_pkg::MAX_ALIGN_LOG2)) ||
                  (in_data_i.req_bytes > max_q)) begin
                pend_d.status = sarena_pkg::ST_BAD;
                state_d       = S_EMIT;
              end else begin
                alog_d  = (in_data_i.align_log2 < 4'(sarena_pkg::MIN_ALIGN_LOG2)) ?
                          4'(sarena_pkg::MIN_ALIGN_LOG2) : in_data_i.align_log2;
                state_d = S_ALC;
              end
            end
            sarena_pkg::CMD_FREE: begin
              if (count_q == 11'd0) begin
                pend_d.status = sarena_pkg::ST_NOTFOUND;
                state_d       = S_EMIT;
              end else begin
                state_d = S_SRCH;
              end
            end
            sarena_pkg::CMD_EXPAND: begin
              if (count_q == 11'd0) begin
                pend_d.status = sarena_pkg::ST_NOTGROWN;
                state_d       = S_EMIT;
              end else begin
                state_d = S_EXP;
              end
            end
            default: begin
              pend_d.status = sarena_pkg::ST_BAD;
              state_d       = S_EMIT;
            end
          endcase
        end
      end

      S_ALC: begin
        size_d  = alc_size;
        pad_d   = (9'd0 - used_q[8:0]) & alc_mask;
        room_d  = (alc_avail >= 13'(sarena_pkg::RECORD_BYTES)) ?
                  alc_avail - 13'(sarena_pkg::RECORD_BYTES) : 13'd0;
        state_d = S_ALC_FIT;
      end

      S_ALC_FIT: begin
        state_d = S_EMIT;
        if ((count_q >= 11'(sarena_pkg::REC_DEPTH)) || ({2'b00, room_q} < fit_need)) begin
          pend_d.status = sarena_pkg::ST_NOSPACE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = count_q[AW-1:0];
          ram_wdata = {fit_off[11:0],
                       3'(alog_q - 4'(sarena_pkg::MIN_ALIGN_LOG2)), 1'b1};
          count_d   = count_q + 11'd1;
          used_d    = used_q + fit_need[12:0];
          pend_d.result_offset = fit_off[11:0];
          pend_d.granted_bytes = size_q[12:0];
        end
      end

      // Read data belongs to addr_q; the next older record is read meanwhile.
      S_SRCH: begin
        ram_raddr = addr_q - AW'(1);
        if (top_off == off_q) begin
          ram_we    = 1'b1;
          ram_waddr = addr_q;
          ram_wdata = {ram_rdata[15:1], 1'b0};
          state_d   = S_POP_RD;
        end else if (addr_q == '0) begin
          pend_d.status = sarena_pkg::ST_NOTFOUND;
          state_d       = S_EMIT;
        end else begin
          addr_d = addr_q - AW'(1);
        end
      end

      S_POP_RD: begin
        if (count_q == 11'd0) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_POP_CHK;
        end
      end

      S_POP_CHK: begin
        if (!ram_rdata[0]) begin
          used_d  = {1'b0, top_off};
          count_d = count_q - 11'd1;
          state_d = S_POP_RD;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_EXP: begin
        if ((top_off != off_q) || ({1'b0, top_off} > used_q)) begin
          pend_d.status = sarena_pkg::ST_NOTGROWN;
          state_d       = S_EMIT;
        end else begin
          cur_d   = top_cur;
          limit_d = top_limit;
          state_d = S_EXP_FIN;
        end
      end

      S_EXP_FIN: begin
        state_d = S_EMIT;
        if (exp_new <= cur_q) begin
          pend_d.status = sarena_pkg::ST_NOTGROWN;
        end else begin
          used_d               = used_q + (exp_new - cur_q);
          pend_d.granted_bytes = exp_new;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      count_q     <= '0;
      max_q       <= 13'(sarena_pkg::ARENA_BYTES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    alog_q  <= alog_d;
    off_q   <= off_d;
    addr_q  <= addr_d;
    size_q  <= size_d;
    pad_q   <= pad_d;
    room_q  <= room_d;
    cur_q   <= cur_d;
    limit_q <= limit_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  sarena_ram #(
    .ADDR_W(AW),
    .DATA_W(sarena_pkg::REC_W)
  ) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
